### design/smch_pkg.sv
// ----------------------------------------------------------------------------
// smch_pkg
// Shared types and codes for the sparse matrix coalesced hash store.
// ----------------------------------------------------------------------------
package smch_pkg;

	localparam int IDX_W      = 16;
	localparam int VAL_W      = 32;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int KEY_W      = 33;
	localparam int HCNT_W     = 6;

	localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [ST_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [ST_W-1:0] STATUS_FULL  = 2'd2;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} slot_data_t;

	typedef struct packed {
		logic             start;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} hash_req_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_MUL,
		H_ADD,
		H_DIV
	} hash_state_t;

	typedef enum logic [4:0] {
		C_CLEAR,
		C_IDLE,
		C_HASH,
		C_MISS,
		C_RESP,
		F_RD,
		F_CHK,
		A_RD,
		A_CHK,
		I_RD,
		I_CHK,
		T_CHK,
		I_LINK,
		I_PUT,
		D_START,
		D_NXT,
		D_SRD,
		D_SCHK,
		D_SHASH,
		D_MOVE,
		D_END,
		D_END2,
		D_END3,
		D_FREE
	} ctrl_state_t;

endpackage

### design/smch_ifs.sv
// ----------------------------------------------------------------------------
// smch_ifs
// Valid/ready channels: request, response and register write.
// ----------------------------------------------------------------------------
interface smch_req_if;
	import smch_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    mode;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic signed [VAL_W-1:0] value;
	modport source (output valid, mode, row, col, value, input ready);
	modport sink (input valid, mode, row, col, value, output ready);
endinterface

interface smch_rsp_if;
	import smch_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;
	logic [ST_W-1:0]         status;
	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

interface smch_cfg_if;
	import smch_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/smch_store.sv
// ----------------------------------------------------------------------------
// smch_store
// Slot memories: link word {valid, next} and data word {row, col, value}.
// One shared read address, one write port each, registered read data.
// ----------------------------------------------------------------------------
module smch_store #(
	parameter int CAPACITY = 1024,
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int LW = PW + 1
) (
	input  logic                clk,
	input  logic [PW-1:0]       rd_addr,
	output logic [LW:0]         meta_rdata,
	output smch_pkg::slot_data_t data_rdata,
	input  logic                meta_we,
	input  logic [PW-1:0]       meta_waddr,
	input  logic [LW:0]         meta_wdata,
	input  logic                data_we,
	input  logic [PW-1:0]       data_waddr,
	input  smch_pkg::slot_data_t data_wdata
);
	import smch_pkg::*;

	logic [LW:0] meta_mem [CAPACITY];
	slot_data_t  data_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		meta_rdata <= meta_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
		data_rdata <= data_mem[rd_addr];
	end

endmodule

### design/smch_hash.sv
// ----------------------------------------------------------------------------
// smch_hash
// Home slot unit: (row * num_cols + col) mod CAPACITY.
// Registered multiply, then a mask, or a restoring remainder one bit a cycle.
// ----------------------------------------------------------------------------
module smch_hash #(
	parameter int CAPACITY = 1024,
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smch_pkg::hash_req_t hreq,
	input  logic [smch_pkg::IDX_W-1:0] num_cols,
	output logic                done,
	output logic [PW-1:0]       home
);
	import smch_pkg::*;

	localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [PW:0] CAP_W = (PW + 1)'(CAPACITY);

	hash_state_t state_q, state_d;
	logic [IDX_W-1:0]  r_q, c_q, nc_q;
	logic [2*IDX_W-1:0] prod_q;
	logic [KEY_W-1:0]  key_q, sum;
	logic [PW-1:0]     rem_q;
	logic [PW:0]       shifted, reduced;
	logic [HCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [PW-1:0]     home_q;

	assign sum     = {1'b0, prod_q} + KEY_W'(c_q);
	assign shifted = {rem_q, key_q[KEY_W-1]};
	assign reduced = (shifted >= CAP_W) ? shifted - CAP_W : shifted;
	assign done    = done_q;
	assign home    = home_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == H_ADD && POW2) ||
				(state_q == H_DIV && cnt_q == '0);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: if (hreq.start) state_d = H_MUL;
			H_MUL:  state_d = H_ADD;
			H_ADD:  state_d = POW2 ? H_IDLE : H_DIV;
			H_DIV:  if (cnt_q == '0) state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				r_q  <= hreq.row;
				c_q  <= hreq.col;
				nc_q <= num_cols;
			end
			H_MUL: prod_q <= r_q * nc_q;
			H_ADD: begin
				key_q  <= sum;
				rem_q  <= '0;
				cnt_q  <= HCNT_W'(KEY_W - 1);
				home_q <= sum[PW-1:0];
			end
			H_DIV: begin
				key_q  <= key_q << 1;
				rem_q  <= reduced[PW-1:0];
				cnt_q  <= cnt_q - 1'b1;
				home_q <= reduced[PW-1:0];
			end
			default: ;
		endcase
	end

endmodule

### design/smch_ctrl.sv
// ----------------------------------------------------------------------------
// smch_ctrl
// Sequencer: chain walk, free-slot scan, insert with tail link, delete with
// hole relink, clearing pass after reset, and the response register.
// ----------------------------------------------------------------------------
module smch_ctrl #(
	parameter int CAPACITY = 1024,
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int LW = PW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	smch_req_if.sink             req,
	smch_rsp_if.source           rsp,
	input  logic [smch_pkg::IDX_W-1:0] num_rows,
	input  logic [smch_pkg::IDX_W-1:0] num_cols,
	output smch_pkg::hash_req_t  hreq,
	input  logic                 h_done,
	input  logic [PW-1:0]        h_home,
	output logic [PW-1:0]        rd_addr,
	input  logic [LW:0]          meta_rdata,
	input  smch_pkg::slot_data_t data_rdata,
	output logic                 meta_we,
	output logic [PW-1:0]        meta_waddr,
	output logic [LW:0]          meta_wdata,
	output logic                 data_we,
	output logic [PW-1:0]        data_waddr,
	output smch_pkg::slot_data_t data_wdata
);
	import smch_pkg::*;

	localparam logic [LW-1:0] CAP_L  = LW'(CAPACITY);
	localparam logic [LW-1:0] NULL_L = '1;
	localparam logic [PW-1:0] LAST   = PW'(CAPACITY - 1);

	ctrl_state_t state_q, state_d;
	logic [PW-1:0] clr_q, clr_d;
	logic [LW-1:0] ff_q, ff_d;
	logic          ov_q, ov_d;

	logic             mode_q, mode_d;
	logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
	logic [VAL_W-1:0] val_q, val_d, old_q, old_d;
	logic [LW-1:0]    cur_q, cur_d, prev_q, prev_d, p_q, p_d, pp_q, pp_d;
	logic [LW-1:0]    cnt_q, cnt_d, round_q, round_d, nxt_q, nxt_d;
	logic [PW-1:0]    home_q, home_d;
	logic             post_q, post_d, lnk_q, lnk_d, tv_q, tv_d;
	slot_data_t       dp_q, dp_d;
	logic [VAL_W-1:0] res_val_q, res_val_d, ores_q, ores_d;
	logic [ST_W-1:0]  res_st_q, res_st_d, ost_q, ost_d;

	logic          mv;
	logic [LW-1:0] mnext;

	assign mv    = meta_rdata[LW];
	assign mnext = meta_rdata[LW-1:0];

	assign rsp.valid        = ov_q;
	assign rsp.result_value = ores_q;
	assign rsp.status       = ost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_CLEAR;
			clr_q   <= '0;
			ff_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			ff_q    <= ff_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q    <= mode_d;
		row_q     <= row_d;
		col_q     <= col_d;
		val_q     <= val_d;
		old_q     <= old_d;
		cur_q     <= cur_d;
		prev_q    <= prev_d;
		p_q       <= p_d;
		pp_q      <= pp_d;
		cnt_q     <= cnt_d;
		round_q   <= round_d;
		nxt_q     <= nxt_d;
		home_q    <= home_d;
		post_q    <= post_d;
		lnk_q     <= lnk_d;
		tv_q      <= tv_d;
		dp_q      <= dp_d;
		res_val_q <= res_val_d;
		res_st_q  <= res_st_d;
		ores_q    <= ores_d;
		ost_q     <= ost_d;
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		ff_d      = ff_q;
		ov_d      = ov_q & ~rsp.ready;
		mode_d    = mode_q;
		row_d     = row_q;
		col_d     = col_q;
		val_d     = val_q;
		old_d     = old_q;
		cur_d     = cur_q;
		prev_d    = prev_q;
		p_d       = p_q;
		pp_d      = pp_q;
		cnt_d     = cnt_q;
		round_d   = round_q;
		nxt_d     = nxt_q;
		home_d    = home_q;
		post_d    = post_q;
		lnk_d     = lnk_q;
		tv_d      = tv_q;
		dp_d      = dp_q;
		res_val_d = res_val_q;
		res_st_d  = res_st_q;
		ores_d    = ores_q;
		ost_d     = ost_q;
		req.ready  = 1'b0;
		hreq       = '0;
		rd_addr    = '0;
		meta_we    = 1'b0;
		meta_waddr = '0;
		meta_wdata = '0;
		data_we    = 1'b0;
		data_waddr = '0;
		data_wdata = '0;

		unique case (state_q)
			C_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
				meta_wdata = {1'b0, NULL_L};
				clr_d      = clr_q + 1'b1;
				if (clr_q == LAST) state_d = C_IDLE;
			end
			C_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					mode_d = req.mode;
					row_d  = req.row;
					col_d  = req.col;
					val_d  = req.value;
					if (req.row >= num_rows || req.col >= num_cols) begin
						res_val_d = '0;
						res_st_d  = STATUS_RANGE;
						state_d   = C_RESP;
					end else begin
						hreq.start = 1'b1;
						hreq.row   = req.row;
						hreq.col   = req.col;
						state_d    = C_HASH;
					end
				end
			end
			C_HASH: begin
				if (h_done) begin
					home_d  = h_home;
					cur_d   = {1'b0, h_home};
					prev_d  = NULL_L;
					cnt_d   = '0;
					state_d = F_RD;
				end
			end
			F_RD: begin
				if (cnt_q >= CAP_L) begin
					state_d = C_MISS;
				end else begin
					rd_addr = cur_q[PW-1:0];
					cnt_d   = cnt_q + 1'b1;
					state_d = F_CHK;
				end
			end
			F_CHK: begin
				if (mv && data_rdata.row == row_q && data_rdata.col == col_q) begin
					old_d     = data_rdata.value;
					res_val_d = data_rdata.value;
					res_st_d  = STATUS_OK;
					if (mode_q == MODE_READ) begin
						state_d = C_RESP;
					end else if (val_q != '0) begin
						data_we    = 1'b1;
						data_waddr = cur_q[PW-1:0];
						data_wdata = '{row: row_q, col: col_q, value: val_q};
						state_d    = C_RESP;
					end else begin
						round_d = '0;
						state_d = D_START;
					end
				end else if (mnext >= CAP_L) begin
					state_d = C_MISS;
				end else begin
					prev_d  = cur_q;
					cur_d   = mnext;
					state_d = F_RD;
				end
			end
			C_MISS: begin
				res_val_d = '0;
				res_st_d  = STATUS_OK;
				if (mode_q == MODE_WRITE && val_q != '0) begin
					post_d  = 1'b0;
					state_d = A_RD;
				end else begin
					state_d = C_RESP;
				end
			end
			A_RD: begin
				if (ff_q >= CAP_L) begin
					res_val_d = '0;
					res_st_d  = post_q ? STATUS_OK : STATUS_FULL;
					state_d   = C_RESP;
				end else begin
					rd_addr = ff_q[PW-1:0];
					state_d = A_CHK;
				end
			end
			A_CHK: begin
				if (mv) begin
					ff_d    = ff_q + 1'b1;
					state_d = A_RD;
				end else if (post_q) begin
					res_val_d = '0;
					res_st_d  = STATUS_OK;
					state_d   = C_RESP;
				end else begin
					state_d = I_RD;
				end
			end
			I_RD: begin
				rd_addr = home_q;
				cur_d   = {1'b0, home_q};
				cnt_d   = '0;
				state_d = I_CHK;
			end
			I_CHK, T_CHK: begin
				// home free: insert there; otherwise follow links to the tail
				if (state_q == I_CHK && !mv) begin
					lnk_d   = 1'b0;
					state_d = I_PUT;
				end else if (cnt_q >= CAP_L || mnext >= CAP_L) begin
					tv_d    = mv;
					state_d = I_LINK;
				end else begin
					cur_d   = mnext;
					cnt_d   = cnt_q + 1'b1;
					rd_addr = mnext[PW-1:0];
					state_d = T_CHK;
				end
			end
			I_LINK: begin
				meta_we    = 1'b1;
				meta_waddr = cur_q[PW-1:0];
				meta_wdata = {tv_q, ff_q};
				lnk_d      = 1'b1;
				state_d    = I_PUT;
			end
			I_PUT: begin
				meta_we    = 1'b1;
				data_we    = 1'b1;
				meta_waddr = lnk_q ? ff_q[PW-1:0] : home_q;
				data_waddr = meta_waddr;
				// a stale tail may be the free slot itself: keep its new self link
				meta_wdata = {1'b1, (lnk_q && cur_q == ff_q) ? ff_q : NULL_L};
				data_wdata = '{row: row_q, col: col_q, value: val_q};
				post_d     = 1'b1;
				state_d    = A_RD;
			end
			D_START: begin
				if (round_q >= CAP_L) begin
					state_d = D_END;
				end else begin
					rd_addr = cur_q[PW-1:0];
					state_d = D_NXT;
				end
			end
			D_NXT: begin
				p_d     = mnext;
				pp_d    = cur_q;
				cnt_d   = '0;
				state_d = D_SRD;
			end
			D_SRD: begin
				if (p_q >= CAP_L || cnt_q >= CAP_L) begin
					state_d = D_END;
				end else begin
					rd_addr = p_q[PW-1:0];
					state_d = D_SCHK;
				end
			end
			D_SCHK: begin
				dp_d  = data_rdata;
				nxt_d = mnext;
				if (mv) begin
					hreq.start = 1'b1;
					hreq.row   = data_rdata.row;
					hreq.col   = data_rdata.col;
					state_d    = D_SHASH;
				end else begin
					pp_d    = p_q;
					p_d     = mnext;
					cnt_d   = cnt_q + 1'b1;
					state_d = D_SRD;
				end
			end
			D_SHASH: begin
				if (h_done) begin
					if ({1'b0, h_home} == cur_q) begin
						state_d = D_MOVE;
					end else begin
						pp_d    = p_q;
						p_d     = nxt_q;
						cnt_d   = cnt_q + 1'b1;
						state_d = D_SRD;
					end
				end
			end
			D_MOVE: begin
				// member that hashes to the hole moves in; its old slot is the new hole
				data_we    = 1'b1;
				data_waddr = cur_q[PW-1:0];
				data_wdata = dp_q;
				prev_d     = pp_q;
				cur_d      = p_q;
				round_d    = round_q + 1'b1;
				state_d    = D_START;
			end
			D_END: begin
				rd_addr = cur_q[PW-1:0];
				state_d = D_END2;
			end
			D_END2: begin
				nxt_d = mnext;
				if (prev_q >= CAP_L) begin
					state_d = D_FREE;
				end else begin
					rd_addr = prev_q[PW-1:0];
					state_d = D_END3;
				end
			end
			D_END3: begin
				meta_we    = 1'b1;
				meta_waddr = prev_q[PW-1:0];
				meta_wdata = {mv, nxt_q};
				state_d    = D_FREE;
			end
			D_FREE: begin
				meta_we    = 1'b1;
				meta_waddr = cur_q[PW-1:0];
				meta_wdata = {1'b0, NULL_L};
				if (ff_q > cur_q) ff_d = cur_q;
				res_val_d = old_q;
				res_st_d  = STATUS_OK;
				state_d   = C_RESP;
			end
			C_RESP: begin
				if (!ov_q || rsp.ready) begin
					ov_d    = 1'b1;
					ores_d  = res_val_q;
					ost_d   = res_st_q;
					state_d = C_IDLE;
				end
			end
			default: state_d = C_IDLE;
		endcase
	end

endmodule

### design/sparse_matrix_coalesced_hash_core.sv
// A read or update hashes to its home slot and then walks the chain link by
// link. When CAPACITY is a power of two the home slot is a mask of the key;
// otherwise the hash runs a remainder, one remainder bit per cycle. Inserts
// also pay for each occupied slot skipped by the free pointer; deletes rehash each later member.
// One request at a time; the slot memory read port sets the walk rate.
// After reset a clearing pass over every slot runs before the first request.
// ----------------------------------------------------------------------------
// sparse_matrix_coalesced_hash_core
// Sparse matrix entry store in a coalesced hash table with register port.
// ----------------------------------------------------------------------------
module sparse_matrix_coalesced_hash_core #(
	parameter int CAPACITY = 1024
) (
	input logic        clk,
	input logic        arst_n,
	smch_cfg_if.sink   cfg,
	smch_req_if.sink   req,
	smch_rsp_if.source rsp
);
	import smch_pkg::*;

	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = PW + 1;

	logic [IDX_W-1:0] num_rows_q, num_cols_q;

	hash_req_t     hreq;
	logic          h_done;
	logic [PW-1:0] h_home;
	logic [PW-1:0] rd_addr, meta_waddr, data_waddr;
	logic [LW:0]   meta_rdata, meta_wdata;
	logic          meta_we, data_we;
	slot_data_t    data_rdata, data_wdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= IDX_W'(1);
			num_cols_q <= IDX_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NUM_ROWS: num_rows_q <= cfg.data;
				REG_NUM_COLS: num_cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	smch_hash #(.CAPACITY(CAPACITY)) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.hreq     (hreq),
		.num_cols (num_cols_q),
		.done     (h_done),
		.home     (h_home)
	);

	smch_store #(.CAPACITY(CAPACITY)) u_store (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.meta_rdata (meta_rdata),
		.data_rdata (data_rdata),
		.meta_we    (meta_we),
		.meta_waddr (meta_waddr),
		.meta_wdata (meta_wdata),
		.data_we    (data_we),
		.data_waddr (data_waddr),
		.data_wdata (data_wdata)
	);

	smch_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.num_rows   (num_rows_q),
		.num_cols   (num_cols_q),
		.hreq       (hreq),
		.h_done     (h_done),
		.h_home     (h_home),
		.rd_addr    (rd_addr),
		.meta_rdata (meta_rdata),
		.data_rdata (data_rdata),
		.meta_we    (meta_we),
		.meta_waddr (meta_waddr),
		.meta_wdata (meta_wdata),
		.data_we    (data_we),
		.data_waddr (data_waddr),
		.data_wdata (data_wdata)
	);

endmodule
